>>> rtl/core/text_console_char_writer_core_defines.svh
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
// Package with the types and constants of the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 4;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;
  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h0F;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/text_console_char_writer_core.sv
// Flow: an accepted put or read item goes from ST_IDLE to ST_DELIVER, and out_valid
// is registered once ST_DELIVER finds the output register free or being taken.
// A put that scrolls the screen first passes ST_SCROLL, one cell copied per cycle
// through the single read port and single write port of the screen memory.
// A new item is taken while the previous result still waits at the output register.
// Reset: the cursor goes to 0, then a pass over all COLUMNS*ROWS cells clears the memory.
`include "text_console_char_writer_core_defines.svh"

module text_console_char_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [COLOR_W-1:0] back_color,
  input  logic [COLOR_W-1:0] fore_color,
  input  logic [POS_W-1:0]   cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   cursor_pos,
  output logic               did_scroll,
  output logic [CHAR_W-1:0]  cell_char,
  output logic [CHAR_W-1:0]  cell_attr
);

  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int COL_W         = $clog2(COLUMNS);
  localparam int SUM_W         = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int CMP_W         = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;

  localparam logic [ADDR_W-1:0] LAST_BASE_A = ADDR_W'(LAST_ROW_BASE);
  localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COLUMNS_A   = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);

  state_t state, state_next;

  logic [ADDR_W-1:0] cnt;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] row_base;
  logic              copy_vld;
  logic [ADDR_W-1:0] copy_dst;
  logic              pend_hit;
  logic              pend_scroll;

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              accept;
  logic              is_put;
  logic              is_newline;
  logic              read_hit;
  logic              wrap;
  logic              need_scroll;
  logic [ADDR_W-1:0] cur_addr;
  logic [SUM_W-1:0]  cur_sum;
  logic              in_copy;
  logic              cnt_step;
  logic              out_load;

  assign accept     = in_valid && in_ready;
  assign is_put     = (op == OP_PUT) && (char_code != NULL_CODE);
  assign is_newline = (char_code == NEWLINE_CODE);
  assign read_hit   = (op == OP_READ) && (CMP_W'(cell_index) < CMP_W'(CELL_COUNT));
  assign wrap       = is_newline || (col == LAST_COL);
  assign need_scroll = is_put && wrap && (row_base == LAST_BASE_A);
  assign cur_addr   = row_base + ADDR_W'(col);
  assign cur_sum    = SUM_W'(row_base) + SUM_W'(col);
  assign in_copy    = (cnt < LAST_BASE_A);
  assign cnt_step   = in_copy || !copy_vld;
  assign out_load   = (state == ST_DELIVER) && (!out_valid || out_ready);

  tcw_screen_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == LAST_CELL_A) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = need_scroll ? ST_SCROLL : ST_DELIVER;
        end
      end
      ST_SCROLL: begin
        if (!copy_vld && (cnt == LAST_CELL_A)) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_ctl   = '0;
    mem_waddr = cnt;
    mem_wdata = '0;
    mem_raddr = ADDR_W'(cell_index);
    unique case (state)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          mem_ctl.rd_en = read_hit;
          mem_ctl.wr_en = is_put && !is_newline;
          mem_waddr     = cur_addr;
          mem_wdata     = {back_color, fore_color, char_code};
        end
      end
      ST_SCROLL: begin
        // Reads run one row ahead of the writes, so they never meet.
        mem_ctl.rd_en = in_copy;
        mem_raddr     = cnt + COLUMNS_A;
        if (copy_vld) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = copy_dst;
          mem_wdata     = mem_rdata;
        end else if (!in_copy) begin
          mem_ctl.wr_en = 1'b1;
          mem_wdata     = {BLANK_ATTR, NULL_CODE};
        end
      end
      ST_DELIVER: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      col       <= '0;
      row_base  <= '0;
      copy_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        cnt <= (cnt == LAST_CELL_A) ? '0 : cnt + 1'b1;
      end
      if (accept) begin
        pend_hit    <= read_hit;
        pend_scroll <= need_scroll;
        cnt         <= '0;
        if (is_put) begin
          if (wrap) begin
            col <= '0;
            if (!need_scroll) begin
              row_base <= row_base + COLUMNS_A;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
      end
      if (state == ST_SCROLL) begin
        copy_vld <= in_copy;
        copy_dst <= cnt;
        if (cnt_step && (cnt != LAST_CELL_A)) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (out_load) begin
        out_valid  <= 1'b1;
        cursor_pos <= cur_sum[POS_W-1:0];
        did_scroll <= pend_scroll;
        cell_char  <= pend_hit ? mem_rdata[CHAR_W-1:0] : '0;
        cell_attr  <= pend_hit ? mem_rdata[CELL_W-1:CHAR_W] : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TCW_ASSERT_IMP(a_rw_apart, mem_ctl.wr_en && mem_ctl.rd_en, mem_waddr != mem_raddr, "same cell")
  `TCW_ASSERT_IMP(a_col_range, state != ST_CLEAR, col <= LAST_COL, "column beyond the row")
  `TCW_ASSERT_IMP(a_row_range, state != ST_CLEAR, row_base <= LAST_BASE_A, "row beyond screen")
  `TCW_ASSERT_NXT(a_busy_after_accept, accept, state != ST_IDLE, "no work after accept")

endmodule

>>> rtl/core/tcw_screen_mem.sv
// Screen cell memory: one write port and one registered read port.
module tcw_screen_mem import tcw_pkg::*; #(
  parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
  parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule
